### rtl/core/f32log2_pkg.sv
package f32log2_pkg;

    localparam logic [31:0] BITS_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] BITS_PINF = 32'h7F80_0000;
    localparam logic [31:0] BITS_NINF = 32'hFF80_0000;
    localparam logic [31:0] BITS_ONE  = 32'h3F80_0000;
    localparam logic [31:0] BITS_MONE = 32'hBF80_0000;

    // polynomial coefficients of the atanh series, scaled for log2
    localparam logic [31:0] COEF_C0 = 32'h4038_AA3B;
    localparam logic [31:0] COEF_C1 = 32'h3F76_3857;
    localparam logic [31:0] COEF_C2 = 32'h3F13_AE49;
    localparam logic [31:0] COEF_C3 = 32'h3EDB_4BD5;

    // significand threshold (top seven fraction bits) for halving
    localparam logic [6:0] HALVE_FRAC = 7'h35;

    // quotient bits produced by the divider, one per stage
    localparam int QBITS = 27;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_bits;
        logic [31:0] ef;
        logic [31:0] s;
        logic [31:0] z;
    } side_t;

    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd32;
        hit = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = 6'(31 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

### rtl/core/float32_log2_top.sv
// Single-precision base-2 logarithm, fully pipelined.
//
// Slave channel (s_*) carries one float32 operand per request in s_tdata;
// master channel (m_*) returns log2 of it as float32 in m_tdata, one
// result per request, in request order.
//
// From an accepted request to m_tvalid an item passes through operand
// screening and normalization, the m-1 / m+1 adders, the divider (load,
// 27 restoring steps with one quotient bit per stage, and rounding), then
// 9 float units for the polynomial and the final exponent add.
// Throughput is one request per cycle while m_tready stays high.
//
// The whole pipeline advances together: when the output holds a result
// that the receiver does not take, every stage holds and s_tready drops,
// so nothing is lost or repeated. Empty slots in the pipe do not block.
// Reset clears every stage valid bit; the datapath is not reset.
// Special operands (NaN, infinities, zeros, negatives) are screened up
// front and ride alongside the datapath to the output.
module float32_log2_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] log_bits
);
    import f32log2_pkg::*;

    logic en;

    // advance whenever the output slot is empty or being drained
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic        fr_vld;
    logic [31:0] fr_m;
    side_t       fr_side;

    f32log2_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(s_tvalid), .x(s_tdata),
        .out_vld(fr_vld), .m(fr_m), .side(fr_side)
    );

    // numerator and denominator of s, in parallel
    logic        num_vld;
    logic [31:0] num;
    side_t       num_side;
    logic [31:0] den;

    f32log2_fadd u_sub (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(fr_vld), .a(fr_m), .b(BITS_MONE), .in_side(fr_side),
        .out_vld(num_vld), .res(num), .out_side(num_side)
    );

    f32log2_fadd u_add (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(fr_vld), .a(fr_m), .b(BITS_ONE), .in_side(fr_side),
        .out_vld(), .res(den), .out_side()
    );

    logic        dv_vld;
    logic [31:0] dv_s;
    side_t       dv_side;
    side_t       s_side;

    f32log2_fdiv u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(num_vld), .a(num), .b(den), .in_side(num_side),
        .out_vld(dv_vld), .res(dv_s), .out_side(dv_side)
    );

    // keep s with the item for the final multiply
    always_comb begin
        s_side   = dv_side;
        s_side.s = dv_s;
    end

    logic        sq_vld;
    logic [31:0] sq_z;
    side_t       sq_side;
    side_t       z_side;

    f32log2_fmul u_sq (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(dv_vld), .a(dv_s), .b(dv_s), .in_side(s_side),
        .out_vld(sq_vld), .res(sq_z), .out_side(sq_side)
    );

    always_comb begin
        z_side   = sq_side;
        z_side.z = sq_z;
    end

    // Horner chain: ((C3*z + C2)*z + C1)*z + C0
    logic        h0_vld, h1_vld, h2_vld, h3_vld, h4_vld, h5_vld;
    logic [31:0] h0, h1, h2, h3, h4, h5;
    side_t       h0_side, h1_side, h2_side, h3_side, h4_side, h5_side;

    f32log2_fmul u_m3 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(sq_vld), .a(COEF_C3), .b(sq_z), .in_side(z_side),
        .out_vld(h0_vld), .res(h0), .out_side(h0_side)
    );

    f32log2_fadd u_a2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(h0_vld), .a(h0), .b(COEF_C2), .in_side(h0_side),
        .out_vld(h1_vld), .res(h1), .out_side(h1_side)
    );

    f32log2_fmul u_m2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(h1_vld), .a(h1), .b(h1_side.z), .in_side(h1_side),
        .out_vld(h2_vld), .res(h2), .out_side(h2_side)
    );

    f32log2_fadd u_a1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(h2_vld), .a(h2), .b(COEF_C1), .in_side(h2_side),
        .out_vld(h3_vld), .res(h3), .out_side(h3_side)
    );

    f32log2_fmul u_m1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(h3_vld), .a(h3), .b(h3_side.z), .in_side(h3_side),
        .out_vld(h4_vld), .res(h4), .out_side(h4_side)
    );

    f32log2_fadd u_a0 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(h4_vld), .a(h4), .b(COEF_C0), .in_side(h4_side),
        .out_vld(h5_vld), .res(h5), .out_side(h5_side)
    );

    logic        p_vld;
    logic [31:0] p;
    side_t       p_side;

    f32log2_fmul u_mp (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(h5_vld), .a(h5_side.s), .b(h5), .in_side(h5_side),
        .out_vld(p_vld), .res(p), .out_side(p_side)
    );

    // e + p; a zero exponent enters as +0, which leaves p unchanged
    logic [31:0] sum;
    side_t       out_side;

    f32log2_fadd u_fin (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(p_vld), .a(p_side.ef), .b(p), .in_side(p_side),
        .out_vld(m_tvalid), .res(sum), .out_side(out_side)
    );

    assign m_tdata = out_side.spec ? out_side.spec_bits : sum;

    a_ready_rule : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output slot");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_spec_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_side.spec |->
            (m_tdata == BITS_QNAN) || (m_tdata == BITS_PINF) || (m_tdata == BITS_NINF))
        else $error("special operand gave an unexpected code");

endmodule

### rtl/core/f32log2_front.sv
module f32log2_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [31:0]          x,
    output logic                 out_vld,
    output logic [31:0]          m,
    output f32log2_pkg::side_t   side
);
    import f32log2_pkg::*;

    logic        vld1_reg;
    logic [22:0] frac_reg;
    logic [8:0]  e_reg;
    logic        spec_reg;
    logic [31:0] spec_bits_reg;

    logic [7:0]  expf;
    logic [22:0] frac;
    logic [5:0]  lz;
    logic [22:0] frac_next;
    logic [8:0]  e_next;
    logic        spec_next;
    logic [31:0] spec_bits_next;

    always_comb begin
        expf           = x[30:23];
        frac           = x[22:0];
        lz             = lzc32({frac, 9'h1FF});
        spec_next      = 1'b1;
        spec_bits_next = BITS_QNAN;
        if (expf == 8'hFF) begin
            if (frac == 23'd0 && !x[31]) spec_bits_next = BITS_PINF;
        end else if (x[30:0] == 31'd0) begin
            spec_bits_next = BITS_NINF;
        end else if (!x[31]) begin
            spec_next = 1'b0;
        end
        if (expf == 8'd0) begin
            // subnormal: move the leading one to the hidden position
            frac_next = 23'(frac << (lz[4:0] + 5'd1));
            e_next    = 9'(-9'sd127 - $signed({3'b000, lz}));
        end else begin
            frac_next = frac;
            e_next    = 9'({1'b0, expf} - 9'd127);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
        end
        if (en) begin
            frac_reg      <= frac_next;
            e_reg         <= e_next;
            spec_reg      <= spec_next;
            spec_bits_reg <= spec_bits_next;
        end
    end

    logic        halve;
    logic [8:0]  e_adj;
    logic [7:0]  mag;
    logic [5:0]  lze;
    logic [31:0] ef_next;
    logic [31:0] m_next;
    logic        vld2_reg;
    logic [31:0] m_reg;
    side_t       side_reg;

    always_comb begin
        halve  = frac_reg[22:16] >= HALVE_FRAC;
        e_adj  = halve ? e_reg + 9'd1 : e_reg;
        m_next = {1'b0, (halve ? 8'd126 : 8'd127), frac_reg};
        mag    = e_adj[8] ? 8'(-e_adj) : e_adj[7:0];
        lze    = lzc32({mag, 24'hFF_FFFF});
        if (e_adj == 9'd0) begin
            ef_next = 32'd0;
        end else begin
            ef_next = {e_adj[8], 8'(8'd134 - {2'b00, lze}),
                       8'(mag << ({1'b0, lze[2:0]} + 4'd1)), 15'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld2_reg <= vld1_reg;
        end
        if (en) begin
            m_reg              <= m_next;
            side_reg.spec      <= spec_reg;
            side_reg.spec_bits <= spec_bits_reg;
            side_reg.ef        <= ef_next;
            side_reg.s         <= 32'd0;
            side_reg.z         <= 32'd0;
        end
    end

    assign out_vld = vld2_reg;
    assign m       = m_reg;
    assign side    = side_reg;

endmodule

### rtl/core/f32log2_fadd.sv
module f32log2_fadd (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [31:0]          a,
    input  logic [31:0]          b,
    input  f32log2_pkg::side_t   in_side,
    output logic                 out_vld,
    output logic [31:0]          res,
    output f32log2_pkg::side_t   out_side
);
    import f32log2_pkg::*;

    logic        swap;
    logic [31:0] xo;
    logic [31:0] yo;
    logic [23:0] mx;
    logic [23:0] my;
    logic [7:0]  d;
    logic [26:0] by;
    logic [26:0] bs;
    logic        stk;
    logic [27:0] sum_next;

    always_comb begin
        swap = b[30:0] > a[30:0];
        xo   = swap ? b : a;
        yo   = swap ? a : b;
        mx   = {|xo[30:23], xo[22:0]};
        my   = {|yo[30:23], yo[22:0]};
        d    = xo[30:23] - yo[30:23];
        by   = {my, 3'b000};
        stk  = 1'b0;
        if (d >= 8'd27) begin
            bs = {26'd0, |my};
        end else begin
            bs  = by >> d[4:0];
            stk = |(by & ~(27'h7FF_FFFF << d[4:0]));
            bs[0] = bs[0] | stk;
        end
        if (xo[31] ^ yo[31]) sum_next = {1'b0, mx, 3'b000} - {1'b0, bs};
        else                 sum_next = {1'b0, mx, 3'b000} + {1'b0, bs};
    end

    logic        vld1_reg;
    logic [27:0] sum_reg;
    logic [7:0]  exp_reg;
    logic        sgn_reg;
    side_t       side1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
        end
        if (en) begin
            sum_reg   <= sum_next;
            exp_reg   <= xo[30:23];
            sgn_reg   <= xo[31];
            side1_reg <= in_side;
        end
    end

    logic [5:0]  lz;
    logic [26:0] n;
    logic [9:0]  expv;
    logic [24:0] mr;
    logic        up;
    logic [31:0] res_next;

    always_comb begin
        lz = lzc32({sum_reg[26:0], 5'h1F});
        if (sum_reg[27]) begin
            n    = {sum_reg[27:2], sum_reg[1] | sum_reg[0]};
            expv = {2'b00, exp_reg} + 10'd1;
        end else begin
            n    = sum_reg[26:0] << lz[4:0];
            expv = {2'b00, exp_reg} - {4'b0000, lz};
        end
        up = n[2] & ((|n[1:0]) | n[3]);
        mr = {1'b0, n[26:3]} + {24'd0, up};
        if (mr[24]) expv = expv + 10'd1;
        if (sum_reg == 28'd0) res_next = 32'd0;
        else                  res_next = {sgn_reg, expv[7:0], mr[22:0]};
    end

    logic        vld2_reg;
    logic [31:0] res_reg;
    side_t       side2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld2_reg <= vld1_reg;
        end
        if (en) begin
            res_reg   <= res_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_vld  = vld2_reg;
    assign res      = res_reg;
    assign out_side = side2_reg;

endmodule

### rtl/core/f32log2_fmul.sv
module f32log2_fmul (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [31:0]          a,
    input  logic [31:0]          b,
    input  f32log2_pkg::side_t   in_side,
    output logic                 out_vld,
    output logic [31:0]          res,
    output f32log2_pkg::side_t   out_side
);
    import f32log2_pkg::*;

    logic        vld1_reg;
    logic [47:0] prod_reg;
    logic [9:0]  exp_reg;
    logic        sgn_reg;
    logic        zero_reg;
    side_t       side1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
        end
        if (en) begin
            prod_reg  <= {1'b1, a[22:0]} * {1'b1, b[22:0]};
            exp_reg   <= {2'b00, a[30:23]} + {2'b00, b[30:23]} - 10'd127;
            sgn_reg   <= a[31] ^ b[31];
            zero_reg  <= (a[30:23] == 8'd0) || (b[30:23] == 8'd0);
            side1_reg <= in_side;
        end
    end

    logic [23:0] mant;
    logic        g;
    logic        st;
    logic [9:0]  expv;
    logic [24:0] mr;
    logic [31:0] res_next;

    always_comb begin
        if (prod_reg[47]) begin
            mant = prod_reg[47:24];
            g    = prod_reg[23];
            st   = |prod_reg[22:0];
            expv = exp_reg + 10'd1;
        end else begin
            mant = prod_reg[46:23];
            g    = prod_reg[22];
            st   = |prod_reg[21:0];
            expv = exp_reg;
        end
        mr = {1'b0, mant} + {24'd0, g & (st | mant[0])};
        if (mr[24]) expv = expv + 10'd1;
        if (zero_reg) res_next = {sgn_reg, 31'd0};
        else          res_next = {sgn_reg, expv[7:0], mr[22:0]};
    end

    logic        vld2_reg;
    logic [31:0] res_reg;
    side_t       side2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld2_reg <= vld1_reg;
        end
        if (en) begin
            res_reg   <= res_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_vld  = vld2_reg;
    assign res      = res_reg;
    assign out_side = side2_reg;

endmodule

### rtl/core/f32log2_fdiv.sv
module f32log2_fdiv (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [31:0]          a,
    input  logic [31:0]          b,
    input  f32log2_pkg::side_t   in_side,
    output logic                 out_vld,
    output logic [31:0]          res,
    output f32log2_pkg::side_t   out_side
);
    import f32log2_pkg::*;

    logic              vld_reg  [0:QBITS];
    logic [25:0]       r_reg    [0:QBITS];
    logic [QBITS-1:0]  q_reg    [0:QBITS];
    logic [23:0]       d_reg    [0:QBITS];
    logic [9:0]        exp_reg  [0:QBITS];
    logic              sgn_reg  [0:QBITS];
    logic              zero_reg [0:QBITS];
    side_t             side_reg [0:QBITS];

    // load divisor, dividend and exponent difference
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
        if (en) begin
            r_reg[0]    <= {2'b00, |a[30:23], a[22:0]};
            q_reg[0]    <= '0;
            d_reg[0]    <= {1'b1, b[22:0]};
            exp_reg[0]  <= {2'b00, a[30:23]} - {2'b00, b[30:23]} + 10'd127;
            sgn_reg[0]  <= a[31] ^ b[31];
            zero_reg[0] <= a[30:23] == 8'd0;
            side_reg[0] <= in_side;
        end
    end

    // one restoring step per stage
    for (genvar i = 0; i < QBITS; i++) begin : g_step
        logic        ge;
        logic [25:0] rs;
        assign ge = r_reg[i] >= {2'b00, d_reg[i]};
        assign rs = ge ? r_reg[i] - {2'b00, d_reg[i]} : r_reg[i];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                r_reg[i+1]    <= {rs[24:0], 1'b0};
                q_reg[i+1]    <= {q_reg[i][QBITS-2:0], ge};
                d_reg[i+1]    <= d_reg[i];
                exp_reg[i+1]  <= exp_reg[i];
                sgn_reg[i+1]  <= sgn_reg[i];
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    logic [QBITS-1:0] qf;
    logic [23:0]      mant;
    logic             g;
    logic             st;
    logic [9:0]       expv;
    logic [24:0]      mr;
    logic [31:0]      res_next;

    always_comb begin
        qf = q_reg[QBITS];
        if (qf[QBITS-1]) begin
            mant = qf[QBITS-1:QBITS-24];
            g    = qf[QBITS-25];
            st   = (|qf[QBITS-26:0]) | (|r_reg[QBITS]);
            expv = exp_reg[QBITS];
        end else begin
            mant = qf[QBITS-2:QBITS-25];
            g    = qf[QBITS-26];
            st   = (|qf[QBITS-27:0]) | (|r_reg[QBITS]);
            expv = exp_reg[QBITS] - 10'd1;
        end
        mr = {1'b0, mant} + {24'd0, g & (st | mant[0])};
        if (mr[24]) expv = expv + 10'd1;
        if (zero_reg[QBITS]) res_next = {sgn_reg[QBITS], 31'd0};
        else                 res_next = {sgn_reg[QBITS], expv[7:0], mr[22:0]};
    end

    logic        vldo_reg;
    logic [31:0] res_reg;
    side_t       sideo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vldo_reg <= 1'b0;
        end else if (en) begin
            vldo_reg <= vld_reg[QBITS];
        end
        if (en) begin
            res_reg   <= res_next;
            sideo_reg <= side_reg[QBITS];
        end
    end

    assign out_vld  = vldo_reg;
    assign res      = res_reg;
    assign out_side = sideo_reg;

endmodule
